>>> hdl/scca_pkg.sv
// scca_pkg: constants, size class table, types and codes of the size class chunk allocator
// no dependencies; imported by scca_store and size_class_chunk_allocator_top
package scca_pkg;

   localparam int NUM_CLASSES  = 64;
   localparam int STACK_DEPTH  = 16;
   localparam int ADDR_BITS    = 32;

   localparam int HEADER_BYTES = 8;
   localparam int CLS_W        = 6;
   localparam int CLS_AW       = $clog2(NUM_CLASSES);
   localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
   localparam int STK_AW       = $clog2(NUM_CLASSES * STACK_DEPTH);
   // compare width covers the 32-bit ports, the address space and one carry bit
   localparam int CMP_W        = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;

   localparam logic [31:0]      LIMIT_RESET = 32'hFFFF_FFFF;
   localparam logic [CMP_W-1:0] ADDR_MAX    = (CMP_W'(1) << ADDR_BITS) - CMP_W'(1);
   localparam logic [7:0]       FLAG_INVALID = 8'h80;
   localparam logic [7:0]       FLAG_UNUSED  = 8'h40;

   localparam logic [31:0] CLASS_BYTES [64] = '{
      32'd0, 32'd17, 32'd18, 32'd24, 32'd38, 32'd51, 32'd56, 32'd64,
      32'd73, 32'd87, 32'd101, 32'd107, 32'd119, 32'd133, 32'd144, 32'd154,
      32'd167, 32'd183, 32'd200, 32'd218, 32'd237, 32'd259, 32'd278, 32'd306,
      32'd333, 32'd365, 32'd403, 32'd442, 32'd492, 32'd547, 32'd605, 32'd674,
      32'd750, 32'd838, 32'd941, 32'd1056, 32'd1187, 32'd1335, 32'd1514, 32'd1719,
      32'd1960, 32'd2247, 32'd2587, 32'd2990, 32'd3474, 32'd4066, 32'd4792, 32'd5704,
      32'd6835, 32'd8203, 32'd10075, 32'd12502, 32'd15691, 32'd19712, 32'd25246, 32'd32260,
      32'd131072, 32'd524288, 32'd2097152, 32'd8388608, 32'd33554432, 32'd134217728,
      32'd536870912, 32'd2147483648
   };

   typedef enum logic [3:0] {
      S_IDLE,
      S_SIZE,
      S_SEARCH,
      S_COUNT_RD,
      S_ALLOC,
      S_POP,
      S_FREE_CHK,
      S_PUSH,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      STAT_RECYCLED   = 3'd0,
      STAT_NEW        = 3'd1,
      STAT_TOO_LARGE  = 3'd2,
      STAT_NO_SPACE   = 3'd3,
      STAT_BAD_MARKER = 3'd4,
      STAT_BAD_CLASS  = 3'd5,
      STAT_STACK_FULL = 3'd6
   } status_type;

   typedef struct packed {
      logic                 cnt_we;
      logic [CNT_W-1:0]     cnt_wdata;
      logic                 stk_we;
      logic [STK_AW-1:0]    stk_addr;
      logic [ADDR_BITS-1:0] stk_wdata;
   } stk_ctl_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] pos;
      logic [5:0]  cls;
      logic [7:0]  marker;
      logic [30:0] csize;
   } res_type;

   function automatic logic [STK_AW-1:0] stack_addr(input logic [CLS_AW-1:0] cls,
                                                     input logic [CNT_W-1:0] slot);
      stack_addr = STK_AW'(cls) * STK_AW'(STACK_DEPTH) + STK_AW'(slot);
   endfunction

endpackage

>>> hdl/scca_store.sv
// scca_store: per-class stack counts (with valid bits) and the free stack memory
// depends on scca_pkg
module scca_store
   import scca_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CLS_AW-1:0]    cls,
   input  stk_ctl_type          ctl,
   output logic [CNT_W-1:0]     cnt_q,
   output logic [ADDR_BITS-1:0] stk_q
);

   logic [CNT_W-1:0]     cnt_mem [NUM_CLASSES];
   logic [ADDR_BITS-1:0] stk_mem [NUM_CLASSES * STACK_DEPTH];
   logic [NUM_CLASSES-1:0] cnt_vld_ff;
   logic [CNT_W-1:0]     cnt_rd_ff;
   logic                 vld_rd_ff;
   logic [ADDR_BITS-1:0] stk_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (ctl.cnt_we) begin
         cnt_vld_ff[cls] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cnt_we) begin
         cnt_mem[cls] <= ctl.cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cls];
      vld_rd_ff <= cnt_vld_ff[cls];
   end

   always_ff @(posedge clock) begin
      if (ctl.stk_we) begin
         stk_mem[ctl.stk_addr] <= ctl.stk_wdata;
      end
      stk_rd_ff <= stk_mem[ctl.stk_addr];
   end

   // a class never written reads as an empty stack
   assign cnt_q = vld_rd_ff ? cnt_rd_ff : '0;
   assign stk_q = stk_rd_ff;

endmodule

>>> hdl/size_class_chunk_allocator_top.sv
// size_class_chunk_allocator_top: allocate/free sequencer over segregated free stacks
// depends on scca_pkg and scca_store
//
//   channel  ports                 role
//   req      req_valid/req_ready   allocate or free transaction in
//   rsp      rsp_valid/rsp_ready   one result transaction out per request
//   csr      csr_wr_en/csr_wr_data arena limit write, no wait
//
// allocate finds the class by a binary search over the size table, one compare per cycle;
// a too-large request is rejected before the search, a recycled entry is read from its stack.
// free checks the position and marker first; a rejected one skips the count read and push.
// count and stack memories have registered reads.
// reset is synchronous; counts are cleared at once by valid bits, no clearing pass.
// a new request is taken while a finished result still waits for rsp_ready.
module size_class_chunk_allocator_top
   import scca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [30:0] req_request_size,
   input  logic [31:0] req_free_position,
   input  logic [7:0]  req_free_marker,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_chunk_position,
   output logic [5:0]  rsp_class_index,
   output logic [7:0]  rsp_marker_out,
   output logic [30:0] rsp_content_size,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [31:0]          limit_ff;
   logic [ADDR_BITS-1:0] end_ff, end_in;
   logic                 action_ff;
   logic [30:0]          req_ff;
   logic [31:0]          upos_ff;
   logic [7:0]           marker_ff;
   logic [31:0]          total_ff;
   logic [CLS_W-1:0]     lo_ff, lo_in, hi_ff, hi_in, cls_ff, cls_in;
   res_type              res_ff, res_in;
   res_type              out_ff;
   logic                 rsp_valid_ff;

   logic [CNT_W-1:0]     cnt_q;
   logic [ADDR_BITS-1:0] stk_q;
   stk_ctl_type          ctl;

   // shared adder and comparator
   logic [CMP_W-1:0] add_a, add_b, sum, cmp_a, cmp_b;
   logic             cmp_lt;

   logic [CLS_W:0]   mid_sum;
   logic [CLS_W-1:0] mid;
   logic [CMP_W-1:0] usable;
   logic             accept, out_free;
   logic             size_ok, free_ok, cls_ok, cnt_zero, cnt_full;

   function automatic logic [7:0] req_free_flags(input logic [7:0] mk);
      req_free_flags = mk & (FLAG_INVALID | FLAG_UNUSED);
   endfunction

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CLS_W:1];
   assign usable   = (CMP_W'(limit_ff) < ADDR_MAX) ? CMP_W'(limit_ff) : ADDR_MAX;
   assign sum      = add_a + add_b;
   assign cmp_lt   = cmp_a < cmp_b;
   assign cnt_zero = (cnt_q == '0);
   assign cnt_full = (cnt_q >= CNT_W'(STACK_DEPTH));
   assign cls_ok   = ({1'b0, marker_ff[CLS_W-1:0]} < (CLS_W+1)'(NUM_CLASSES));

   // operand selection for the shared unit
   always_comb begin
      add_a = CMP_W'(end_ff);
      add_b = CMP_W'(CLASS_BYTES[cls_ff]);
      cmp_a = CMP_W'(total_ff);
      cmp_b = CMP_W'(CLASS_BYTES[NUM_CLASSES-1]);
      case (state_ff)
         S_SEARCH: begin
            cmp_a = CMP_W'(CLASS_BYTES[mid]);
            cmp_b = CMP_W'(total_ff);
         end
         S_ALLOC: begin
            cmp_a = usable;
            cmp_b = sum;
         end
         S_FREE_CHK, S_PUSH: begin
            // marker position is the user position minus one
            add_a = CMP_W'(upos_ff);
            add_b = '1;
            cmp_a = sum;
            cmp_b = CMP_W'(end_ff);
         end
         default: begin
         end
      endcase
   end

   assign size_ok = cmp_lt;
   assign free_ok = (upos_ff != '0) && (sum >= CMP_W'(HEADER_BYTES)) && cmp_lt &&
                    ((req_free_flags(marker_ff)) == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_action ? S_FREE_CHK : S_SIZE;
            end
         end
         S_SIZE:     state_in = size_ok ? S_SEARCH : S_DONE;
         S_SEARCH: begin
            if (lo_ff == hi_ff) begin
               state_in = S_COUNT_RD;
            end
         end
         S_COUNT_RD: state_in = action_ff ? S_PUSH : S_ALLOC;
         S_ALLOC:    state_in = cnt_zero ? S_DONE : S_POP;
         S_POP:      state_in = S_DONE;
         S_FREE_CHK: state_in = (free_ok && cls_ok) ? S_COUNT_RD : S_DONE;
         S_PUSH:     state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cls_in        = cls_ff;
      end_in        = end_ff;
      res_in        = res_ff;
      ctl.cnt_we    = 1'b0;
      ctl.cnt_wdata = cnt_q;
      ctl.stk_we    = 1'b0;
      ctl.stk_addr  = stack_addr(cls_ff[CLS_AW-1:0], cnt_q);
      ctl.stk_wdata = ADDR_BITS'(sum);
      case (state_ff)
         S_SIZE: begin
            lo_in = '0;
            hi_in = CLS_W'(NUM_CLASSES - 1);
            res_in = '{STAT_TOO_LARGE, 32'd0, 6'd0, 8'd0, 31'd0};
         end
         S_SEARCH: begin
            if (lo_ff == hi_ff) begin
               cls_in = lo_ff;
            end else if (cmp_lt) begin
               lo_in = mid + CLS_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         S_ALLOC: begin
            if (!cnt_zero) begin
               // pop: the top entry is read into the store's output register
               ctl.cnt_we    = 1'b1;
               ctl.cnt_wdata = cnt_q - CNT_W'(1);
               ctl.stk_addr  = stack_addr(cls_ff[CLS_AW-1:0], cnt_q - CNT_W'(1));
            end else if (cmp_lt) begin
               res_in = '{STAT_NO_SPACE, 32'd0, cls_ff, 8'd0, 31'd0};
            end else begin
               end_in = ADDR_BITS'(sum);
               res_in = '{STAT_NEW, 32'(CMP_W'(end_ff) + CMP_W'(1)), cls_ff,
                          8'(cls_ff), req_ff};
            end
         end
         S_POP: begin
            res_in = '{STAT_RECYCLED, 32'(CMP_W'(stk_q) + CMP_W'(1)), cls_ff,
                       8'(cls_ff), req_ff};
         end
         S_FREE_CHK: begin
            if (!free_ok) begin
               res_in = '{STAT_BAD_MARKER, upos_ff, 6'd0, marker_ff, 31'd0};
            end else if (!cls_ok) begin
               res_in = '{STAT_BAD_CLASS, upos_ff, marker_ff[CLS_W-1:0], marker_ff, 31'd0};
            end else begin
               cls_in = marker_ff[CLS_W-1:0];
            end
         end
         S_PUSH: begin
            if (cnt_full) begin
               res_in = '{STAT_STACK_FULL, upos_ff, cls_ff, marker_ff, 31'd0};
            end else begin
               ctl.cnt_we    = 1'b1;
               ctl.cnt_wdata = cnt_q + CNT_W'(1);
               ctl.stk_we    = 1'b1;
               res_in = '{STAT_RECYCLED, upos_ff, cls_ff, marker_ff | FLAG_UNUSED, 31'd0};
            end
         end
         default: begin
         end
      endcase
   end

   scca_store u_store (
      .clock (clock),
      .reset (reset),
      .cls   (cls_ff[CLS_AW-1:0]),
      .ctl   (ctl),
      .cnt_q (cnt_q),
      .stk_q (stk_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         end_ff       <= ADDR_BITS'(HEADER_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         req_ff    <= req_request_size;
         upos_ff   <= req_free_position;
         marker_ff <= req_free_marker;
         total_ff  <= 32'(req_request_size) + 32'd1;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      cls_ff <= cls_in;
      res_ff <= res_in;
      if (state_ff == S_DONE && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_chunk_position = out_ff.pos;
   assign rsp_class_index    = out_ff.cls;
   assign rsp_marker_out     = out_ff.marker;
   assign rsp_content_size   = out_ff.csize;

endmodule
